/* hw/rtl/sdo_expedited_client_core_assert.svh */
// Assertion helpers shared by the SDO client RTL.
`ifndef SDO_EXPEDITED_CLIENT_CORE_ASSERT_SVH
`define SDO_EXPEDITED_CLIENT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SDO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("SDO client assertion failed");

// Next-cycle implication, checked outside reset.
`define SDO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("SDO client assertion failed");

`endif

/* hw/rtl/sdo_pkg.sv */
package sdo_pkg;

    // Event codes carried in the mode field.
    localparam logic [2:0] MODE_START_WRITE = 3'd0;
    localparam logic [2:0] MODE_START_READ  = 3'd1;
    localparam logic [2:0] MODE_FRAME       = 3'd2;
    localparam logic [2:0] MODE_TICK        = 3'd3;
    localparam logic [2:0] MODE_REFUSED     = 3'd4;

    localparam logic OUT_TRANSMIT = 1'b0;
    localparam logic OUT_FINISH   = 1'b1;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_REFUSED    = 3'd1;
    localparam logic [2:0] STATUS_EXHAUSTED  = 3'd2;
    localparam logic [2:0] STATUS_ABORT      = 3'd3;
    localparam logic [2:0] STATUS_UNEXPECTED = 3'd4;
    localparam logic [2:0] STATUS_BAD_SIZE   = 3'd5;

    // Pending operation after a start.
    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_READ_S32 = 2'd1;
    localparam logic [1:0] OP_READ_U16 = 2'd2;
    localparam logic [1:0] OP_READ_U32 = 2'd3;

    localparam logic [1:0] KIND_U32 = 2'd2;

    localparam logic [2:0] SIZE_1 = 3'd1;
    localparam logic [2:0] SIZE_2 = 3'd2;
    localparam logic [2:0] SIZE_4 = 3'd4;

    localparam logic [10:0] ID_REQUEST_BASE = 11'h600;
    localparam logic [10:0] ID_REPLY_BASE   = 11'h580;

    localparam logic [7:0] CMD_WRITE_1     = 8'h2F;
    localparam logic [7:0] CMD_WRITE_2     = 8'h2B;
    localparam logic [7:0] CMD_WRITE_4     = 8'h23;
    localparam logic [7:0] CMD_READ        = 8'h40;
    localparam logic [7:0] CMD_ABORT       = 8'h80;
    localparam logic [7:0] CMD_WRITE_ACK   = 8'h60;
    localparam logic [7:0] CMD_READ_4      = 8'h43;
    localparam logic [7:0] CMD_READ_NOSIZE = 8'h42;
    localparam logic [7:0] CMD_READ_2      = 8'h4B;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NODE_NUMBER   = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [1:0] CFG_ATTEMPT_LIMIT = 2'd2;

    localparam logic [6:0]  NODE_RESET    = 7'd1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [7:0]  ATTEMPT_RESET = 8'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic [15:0]        obj_index;
        logic [7:0]         obj_subindex;
        logic signed [31:0] write_value;
        logic [2:0]         write_size;
        logic [1:0]         read_kind;
        logic [10:0]        frame_id;
        logic [7:0]         frame_cmd;
        logic [31:0]        frame_payload;
    } t_sdo_in;

    typedef struct packed {
        logic        out_kind;
        logic [10:0] tx_ident;
        logic [63:0] tx_bytes;
        logic [2:0]  status;
        logic [31:0] read_value;
        logic [31:0] abort_code;
    } t_sdo_out;

endpackage

/* hw/rtl/sdo_expedited_client_core.sv */
// Channel  Direction  Handshake                Beat payload
// in       input      i_in_valid / o_in_stall  t_sdo_in: one event
// out      output     o_out_valid / i_out_stall t_sdo_out: transmit or finish
// cfg      input      i_cfg_valid / o_cfg_ready index 0..2, 16-bit data
//
// One event is taken every cycle while o_in_stall is low and goes into the input
// register; one decode-and-update pass sets its result in the result register.
// Reset is synchronous and active low; it clears the valids and the transaction
// state and loads the configuration defaults.
// A stall on the output holds the result register and, once the input register
// is also full, raises o_in_stall. The configuration port is always ready.
module sdo_expedited_client_core
    import sdo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_sdo_in     i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_sdo_out    o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    t_sdo_in     r_in;
    logic        r_out_valid;
    t_sdo_out    r_out;

    logic [6:0]  r_node;
    logic [15:0] r_timeout;
    logic [7:0]  r_attempt_limit;

    logic        r_busy;
    logic [1:0]  r_pending_op;
    logic [7:0]  r_attempts;
    logic [15:0] r_ticks;
    logic [63:0] r_saved;

    logic        n_busy;
    logic [1:0]  n_pending_op;
    logic [7:0]  n_attempts;
    logic [15:0] n_ticks;
    logic [63:0] n_saved;
    logic        n_res_valid;
    t_sdo_out    n_res;

    logic        advance;
    logic [15:0] lim;
    logic [7:0]  att;
    logic [16:0] tick_next;
    logic [7:0]  wr_cmd;
    logic [31:0] wr_val;
    logic        size_ok;
    logic        reply_ok;
    logic [1:0]  read_op;
    logic        res_finish;
    logic        res_transmit;

    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    assign lim       = (r_timeout == 16'd0) ? 16'd1 : r_timeout;
    assign att       = (r_attempt_limit == 8'd0) ? 8'd1 : r_attempt_limit;
    assign tick_next = {1'b0, r_ticks} + 17'd1;
    assign read_op   = ((r_in.read_kind > KIND_U32) ? KIND_U32 : r_in.read_kind) + 2'd1;

    assign res_finish   = advance && n_res_valid && n_res.out_kind == OUT_FINISH;
    assign res_transmit = advance && n_res_valid && n_res.out_kind == OUT_TRANSMIT;

    always_comb begin
        size_ok = 1'b1;
        wr_cmd  = CMD_WRITE_4;
        wr_val  = r_in.write_value[31:0];
        case (r_in.write_size)
            SIZE_1: begin
                wr_cmd = CMD_WRITE_1;
                wr_val = {24'd0, r_in.write_value[7:0]};
            end
            SIZE_2: begin
                wr_cmd = CMD_WRITE_2;
                wr_val = {16'd0, r_in.write_value[15:0]};
            end
            SIZE_4: begin
                wr_cmd = CMD_WRITE_4;
            end
            default: begin
                size_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (r_pending_op)
            OP_WRITE:    reply_ok = (r_in.frame_cmd == CMD_WRITE_ACK);
            OP_READ_S32: reply_ok = (r_in.frame_cmd == CMD_READ_4)
                                 || (r_in.frame_cmd == CMD_READ_NOSIZE);
            OP_READ_U16: reply_ok = (r_in.frame_cmd == CMD_READ_2);
            default:     reply_ok = (r_in.frame_cmd == CMD_READ_4);
        endcase
    end

    always_comb begin
        n_busy       = r_busy;
        n_pending_op = r_pending_op;
        n_attempts   = r_attempts;
        n_ticks      = r_ticks;
        n_saved      = r_saved;
        n_res_valid  = 1'b0;
        n_res        = '0;
        if (r_in_valid) begin
            case (r_in.mode)
                MODE_START_WRITE, MODE_START_READ: begin
                    if (!r_busy) begin
                        n_res_valid = 1'b1;
                        if (r_in.mode == MODE_START_WRITE && !size_ok) begin
                            // Bad size finishes at once and the block stays idle.
                            n_ticks          = 16'd0;
                            n_res.out_kind   = OUT_FINISH;
                            n_res.status     = STATUS_BAD_SIZE;
                        end else begin
                            if (r_in.mode == MODE_START_WRITE) begin
                                n_saved      = {wr_val, r_in.obj_subindex, r_in.obj_index,
                                                wr_cmd};
                                n_pending_op = OP_WRITE;
                            end else begin
                                n_saved      = {32'd0, r_in.obj_subindex, r_in.obj_index,
                                                CMD_READ};
                                n_pending_op = read_op;
                            end
                            n_busy           = 1'b1;
                            n_attempts       = 8'd1;
                            n_ticks          = 16'd0;
                            n_res.out_kind   = OUT_TRANSMIT;
                            n_res.tx_ident   = ID_REQUEST_BASE + {4'd0, r_node};
                            n_res.tx_bytes   = n_saved;
                        end
                    end
                end
                MODE_REFUSED: begin
                    if (r_busy) begin
                        n_busy         = 1'b0;
                        n_ticks        = 16'd0;
                        n_res_valid    = 1'b1;
                        n_res.out_kind = OUT_FINISH;
                        n_res.status   = STATUS_REFUSED;
                    end
                end
                MODE_TICK: begin
                    if (r_busy) begin
                        if (tick_next < {1'b0, lim}) begin
                            n_ticks = tick_next[15:0];
                        end else if (r_attempts >= att) begin
                            n_busy         = 1'b0;
                            n_ticks        = 16'd0;
                            n_res_valid    = 1'b1;
                            n_res.out_kind = OUT_FINISH;
                            n_res.status   = STATUS_EXHAUSTED;
                        end else begin
                            n_attempts     = r_attempts + 8'd1;
                            n_ticks        = 16'd0;
                            n_res_valid    = 1'b1;
                            n_res.out_kind = OUT_TRANSMIT;
                            n_res.tx_ident = ID_REQUEST_BASE + {4'd0, r_node};
                            n_res.tx_bytes = r_saved;
                        end
                    end
                end
                MODE_FRAME: begin
                    if (r_busy && r_in.frame_id == ID_REPLY_BASE + {4'd0, r_node}) begin
                        n_busy         = 1'b0;
                        n_ticks        = 16'd0;
                        n_res_valid    = 1'b1;
                        n_res.out_kind = OUT_FINISH;
                        if (r_in.frame_cmd == CMD_ABORT) begin
                            n_res.status     = STATUS_ABORT;
                            n_res.abort_code = r_in.frame_payload;
                        end else if (!reply_ok) begin
                            n_res.status = STATUS_UNEXPECTED;
                        end else begin
                            n_res.status = STATUS_OK;
                            if (r_pending_op == OP_READ_U16) begin
                                n_res.read_value = {16'd0, r_in.frame_payload[15:0]};
                            end else if (r_pending_op != OP_WRITE) begin
                                n_res.read_value = r_in.frame_payload;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_node          <= NODE_RESET;
            r_timeout       <= TIMEOUT_RESET;
            r_attempt_limit <= ATTEMPT_RESET;
            r_busy          <= 1'b0;
            r_pending_op    <= OP_WRITE;
            r_attempts      <= 8'd0;
            r_ticks         <= 16'd0;
            r_saved         <= 64'd0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= n_res_valid;
                if (r_in_valid) begin
                    r_busy       <= n_busy;
                    r_pending_op <= n_pending_op;
                    r_attempts   <= n_attempts;
                    r_ticks      <= n_ticks;
                    r_saved      <= n_saved;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NODE_NUMBER:   r_node          <= i_cfg_data[6:0];
                    CFG_TIMEOUT_TICKS: r_timeout       <= i_cfg_data;
                    CFG_ATTEMPT_LIMIT: r_attempt_limit <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_res;
        end
    end

`include "sdo_expedited_client_core_assert.svh"

    // A finish beat always leaves the client idle.
    `SDO_ASSERT_NEXT(a_finish_idle, i_clk, i_rst_n, res_finish, !r_busy)
    // A transmit beat always leaves a live transaction with an attempt counted.
    `SDO_ASSERT_NEXT(a_tx_busy, i_clk, i_rst_n, res_transmit, r_busy && r_attempts != 8'd0)
    // A transaction in flight has used at least one attempt.
    `SDO_ASSERT_NOW(a_busy_attempts, i_clk, i_rst_n, r_busy, r_attempts != 8'd0)

endmodule

/* tb/sdo_expedited_client_core_tb.sv */
module sdo_expedited_client_core_tb;
    import sdo_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PRINT_LIMIT   = 100;

    localparam logic [1:0] KIND_S32   = 2'd0;
    localparam logic [1:0] KIND_U16   = 2'd1;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    // Tracks the SDO transaction state and the frames and finishes it must produce.
    class sdo_client_scoreboard;
        logic [6:0]  node_number;
        logic [15:0] timeout_ticks;
        logic [7:0]  attempt_limit;
        bit          busy;
        logic [1:0]  pending_op;
        logic [7:0]  attempts_used;
        logic [15:0] ticks_waited;
        logic [63:0] saved_request;
        t_sdo_out    awaited_results[$];
        int          errors;
        int          results_seen;

        function new();
            node_number   = NODE_RESET;
            timeout_ticks = TIMEOUT_RESET;
            attempt_limit = ATTEMPT_RESET;
            busy          = 1'b0;
            pending_op    = OP_WRITE;
            attempts_used = '0;
            ticks_waited  = '0;
            saved_request = '0;
            errors        = 0;
            results_seen  = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [15:0] data);
            case (index)
                CFG_NODE_NUMBER:   node_number   = data[6:0];
                CFG_TIMEOUT_TICKS: timeout_ticks = data;
                CFG_ATTEMPT_LIMIT: attempt_limit = data[7:0];
                default: ;
            endcase
        endfunction

        // The request identifier always follows the node number in force right now.
        function void push_transmit();
            t_sdo_out r;
            r          = '0;
            r.out_kind = OUT_TRANSMIT;
            r.tx_ident = ID_REQUEST_BASE + {4'd0, node_number};
            r.tx_bytes = saved_request;
            awaited_results.push_back(r);
        endfunction

        function void push_finish(logic [2:0] status, logic [31:0] value, logic [31:0] code);
            t_sdo_out r;
            busy         = 1'b0;
            ticks_waited = '0;
            r            = '0;
            r.out_kind   = OUT_FINISH;
            r.status     = status;
            r.read_value = value;
            r.abort_code = code;
            awaited_results.push_back(r);
        endfunction

        function void note_event(t_sdo_in ev);
            logic [31:0] value;
            logic [7:0]  cmd_byte;
            logic        reply_ok;
            logic [16:0] next_ticks;
            logic [15:0] tick_limit;
            logic [7:0]  attempt_cap;
            value = ev.write_value;
            if (ev.mode == MODE_START_WRITE || ev.mode == MODE_START_READ) begin
                if (busy)
                    return;
                if (ev.mode == MODE_START_WRITE) begin
                    case (ev.write_size)
                        SIZE_1: begin
                            cmd_byte = CMD_WRITE_1;
                            value    = value & 32'h0000_00FF;
                        end
                        SIZE_2: begin
                            cmd_byte = CMD_WRITE_2;
                            value    = value & 32'h0000_FFFF;
                        end
                        SIZE_4: begin
                            cmd_byte = CMD_WRITE_4;
                        end
                        default: begin
                            push_finish(STATUS_BAD_SIZE, '0, '0);
                            return;
                        end
                    endcase
                    saved_request = {value, ev.obj_subindex, ev.obj_index, cmd_byte};
                    pending_op    = OP_WRITE;
                end else begin
                    saved_request = {32'h0, ev.obj_subindex, ev.obj_index, CMD_READ};
                    pending_op    = (ev.read_kind > KIND_U32) ? OP_READ_U32
                                                              : ev.read_kind + 2'd1;
                end
                busy          = 1'b1;
                attempts_used = 8'd1;
                ticks_waited  = '0;
                push_transmit();
                return;
            end
            if (!busy)
                return;
            case (ev.mode)
                MODE_REFUSED: begin
                    push_finish(STATUS_REFUSED, '0, '0);
                end
                MODE_TICK: begin
                    tick_limit  = (timeout_ticks == '0) ? 16'd1 : timeout_ticks;
                    attempt_cap = (attempt_limit == '0) ? 8'd1 : attempt_limit;
                    next_ticks  = {1'b0, ticks_waited} + 17'd1;
                    if (next_ticks < {1'b0, tick_limit}) begin
                        ticks_waited = next_ticks[15:0];
                    end else if (attempts_used >= attempt_cap) begin
                        push_finish(STATUS_EXHAUSTED, '0, '0);
                    end else begin
                        attempts_used = attempts_used + 8'd1;
                        ticks_waited  = '0;
                        push_transmit();
                    end
                end
                MODE_FRAME: begin
                    if (ev.frame_id != ID_REPLY_BASE + {4'd0, node_number})
                        return;
                    if (ev.frame_cmd == CMD_ABORT) begin
                        push_finish(STATUS_ABORT, '0, ev.frame_payload);
                        return;
                    end
                    case (pending_op)
                        OP_WRITE:    reply_ok = (ev.frame_cmd == CMD_WRITE_ACK);
                        OP_READ_S32: reply_ok = (ev.frame_cmd == CMD_READ_4 ||
                                                 ev.frame_cmd == CMD_READ_NOSIZE);
                        OP_READ_U16: reply_ok = (ev.frame_cmd == CMD_READ_2);
                        default:     reply_ok = (ev.frame_cmd == CMD_READ_4);
                    endcase
                    if (!reply_ok)
                        push_finish(STATUS_UNEXPECTED, '0, '0);
                    else if (pending_op == OP_WRITE)
                        push_finish(STATUS_OK, '0, '0);
                    else if (pending_op == OP_READ_U16)
                        push_finish(STATUS_OK, {16'h0, ev.frame_payload[15:0]}, '0);
                    else
                        push_finish(STATUS_OK, ev.frame_payload, '0);
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            // Keep the log readable when a broken block floods mismatches.
            if (errors < PRINT_LIMIT)
                $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_sdo_out got);
            t_sdo_out want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                report($sformatf("result %0d arrived with nothing pending: %h",
                                 results_seen, got));
                return;
            end
            want = awaited_results.pop_front();
            if (got.out_kind !== want.out_kind)
                report($sformatf("result %0d out_kind: expected %0d, got %0d",
                                 results_seen, want.out_kind, got.out_kind));
            if (got.tx_ident !== want.tx_ident)
                report($sformatf("result %0d tx_ident: expected %h, got %h",
                                 results_seen, want.tx_ident, got.tx_ident));
            if (got.tx_bytes !== want.tx_bytes)
                report($sformatf("result %0d tx_bytes: expected %h, got %h",
                                 results_seen, want.tx_bytes, got.tx_bytes));
            if (got.status !== want.status)
                report($sformatf("result %0d status: expected %0d, got %0d",
                                 results_seen, want.status, got.status));
            if (got.read_value !== want.read_value)
                report($sformatf("result %0d read_value: expected %h, got %h",
                                 results_seen, want.read_value, got.read_value));
            if (got.abort_code !== want.abort_code)
                report($sformatf("result %0d abort_code: expected %h, got %h",
                                 results_seen, want.abort_code, got.abort_code));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_sdo_in     in_item;
    logic        out_valid;
    logic        out_stall;
    t_sdo_out    out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    sdo_client_scoreboard sb;
    bit idle_on;
    int items_sent;
    int stall_left = 0;
    int cycles;

    sdo_expedited_client_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Output back-pressure comes in short random bursts.
    always @(negedge clk) begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 6);
        out_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left = stall_left - 1;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_sdo_in random_item(logic [2:0] mode);
        t_sdo_in it;
        it.mode          = mode;
        it.obj_index     = 16'($urandom);
        it.obj_subindex  = 8'($urandom);
        it.write_value   = $urandom;
        it.write_size    = 3'($urandom);
        it.read_kind     = 2'($urandom);
        it.frame_id      = 11'($urandom);
        it.frame_cmd     = 8'($urandom);
        it.frame_payload = $urandom;
        return it;
    endfunction

    function automatic logic [10:0] reply_id();
        return ID_REPLY_BASE + {4'd0, sb.node_number};
    endfunction

    task automatic send_event(t_sdo_in ev);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= ev;
        do @(posedge clk); while (in_stall);
        sb.note_event(ev);
        items_sent++;
    endtask

    task automatic send_plain(logic [2:0] mode);
        send_event(random_item(mode));
    endtask

    task automatic send_write(logic [2:0] size, logic [15:0] idx, logic [7:0] sub,
                              logic [31:0] value);
        t_sdo_in ev;
        ev              = random_item(MODE_START_WRITE);
        ev.write_size   = size;
        ev.obj_index    = idx;
        ev.obj_subindex = sub;
        ev.write_value  = value;
        send_event(ev);
    endtask

    task automatic send_read(logic [1:0] kind);
        t_sdo_in ev;
        ev           = random_item(MODE_START_READ);
        ev.read_kind = kind;
        send_event(ev);
    endtask

    task automatic send_frame(logic [10:0] id, logic [7:0] cmd, logic [31:0] payload);
        t_sdo_in ev;
        ev               = random_item(MODE_FRAME);
        ev.frame_id      = id;
        ev.frame_cmd     = cmd;
        ev.frame_payload = payload;
        send_event(ev);
    endtask

    task automatic send_reply(logic [7:0] cmd, logic [31:0] payload);
        send_frame(reply_id(), cmd, payload);
    endtask

    task automatic drain(int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        // Ticks and ignored frames leave no result behind, so give them time to clear.
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [6:0] node, logic [15:0] ticks, logic [7:0] attempts);
        drain(SETTLE_CYCLES);
        write_register(CFG_NODE_NUMBER, {9'd0, node});
        write_register(CFG_TIMEOUT_TICKS, ticks);
        write_register(CFG_ATTEMPT_LIMIT, {8'd0, attempts});
    endtask

    // One start followed by the events a real bus would deliver, with some noise.
    task automatic run_transaction();
        logic [2:0]  size;
        logic [1:0]  kind;
        logic [7:0]  good_cmd;
        int unsigned span;
        int unsigned ending;
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 2))
                0:       size = SIZE_1;
                1:       size = SIZE_2;
                default: size = SIZE_4;
            endcase
            if ($urandom_range(0, 9) == 0)
                size = 3'($urandom_range(0, 7));
            send_write(size, 16'($urandom), 8'($urandom), $urandom);
            if (size != SIZE_1 && size != SIZE_2 && size != SIZE_4)
                return;
            good_cmd = CMD_WRITE_ACK;
        end else begin
            kind = 2'($urandom_range(0, 3));
            send_read(kind);
            if (kind == KIND_S32)
                good_cmd = ($urandom_range(0, 1) == 0) ? CMD_READ_4 : CMD_READ_NOSIZE;
            else if (kind == KIND_U16)
                good_cmd = CMD_READ_2;
            else
                good_cmd = CMD_READ_4;
        end
        if ($urandom_range(0, 9) == 0)
            send_plain(3'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 2))
                0:       send_plain(MODE_TICK);
                1:       send_frame(11'($urandom), 8'($urandom), $urandom);
                default: send_plain(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)));
            endcase
        end
        if ($urandom_range(0, 3) == 0) begin
            span = ((sb.timeout_ticks == '0) ? 1 : sb.timeout_ticks) *
                   ((sb.attempt_limit == '0) ? 1 : sb.attempt_limit) + 1;
            if (span > 40)
                span = 40;
            repeat ($urandom_range(1, span)) send_plain(MODE_TICK);
        end
        ending = $urandom_range(0, 9);
        if (ending < 6)
            send_reply(good_cmd, $urandom);
        else if (ending == 6)
            send_reply(CMD_ABORT, $urandom);
        else if (ending == 7)
            send_reply(8'($urandom), $urandom);
        else if (ending == 8)
            send_plain(MODE_REFUSED);
        if ($urandom_range(0, 9) == 0)
            send_reply(good_cmd, $urandom);
    endtask

    task automatic run_random(int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 6) == 0)
                send_plain(3'($urandom_range(0, 7)));
            else
                run_transaction();
        end
    endtask

    initial begin
        sb         = new();
        idle_on    = 1'b0;
        items_sent = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        set_config(7'd5, 16'd2, 8'd2);
        send_reply(CMD_WRITE_ACK, 32'h0);
        send_plain(MODE_REFUSED);
        send_write(3'd0, 16'h1234, 8'h56, 32'h1);
        send_write(SIZE_1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_read(KIND_S32);
        send_frame(reply_id() + 11'd1, CMD_WRITE_ACK, 32'h0);
        send_plain(MODE_SPARE_FIRST);
        send_reply(CMD_WRITE_ACK, 32'hFFFF_FFFF);
        send_write(SIZE_2, 16'h0000, 8'h00, 32'hFFFF_FFFF);
        send_reply(CMD_ABORT, 32'hFFFF_FFFF);
        send_write(SIZE_4, 16'h8001, 8'h80, 32'h8000_0000);
        send_reply(CMD_READ_4, 32'h0);
        send_read(KIND_S32);
        send_reply(CMD_READ_NOSIZE, 32'h8000_0001);
        send_read(KIND_U16);
        send_reply(CMD_READ_2, 32'hFFFF_FFFF);
        send_read(KIND_U32);
        send_reply(CMD_READ_4, 32'h7FFF_FFFF);
        // The spare read kind behaves as unsigned 32-bit; run it out of attempts.
        send_read(KIND_SPARE);
        repeat (4) send_plain(MODE_TICK);
        send_read(KIND_S32);
        send_plain(MODE_REFUSED);

        idle_on = 1'b1;
        set_config(7'd127, 16'd1, 8'd1);
        run_random(200);
        set_config(7'd1, 16'd0, 8'd0);
        run_random(200);

        // Longest retransmit chain: every tick times out until the attempt cap.
        set_config(7'd64, 16'd1, 8'd255);
        send_plain(MODE_REFUSED);
        send_read(2'($urandom_range(0, 3)));
        repeat (256) send_plain(MODE_TICK);
        run_random(100);

        set_config(7'($urandom_range(1, 127)), 16'hFFFF, 8'd255);
        idle_on = 1'($urandom_range(0, 1));
        run_random(200);

        idle_on = 1'b1;
        repeat (4) begin
            set_config(7'($urandom_range(1, 127)), 16'($urandom_range(1, 6)),
                       8'($urandom_range(1, 4)));
            run_random(200);
        end

        set_config(7'($urandom_range(1, 127)), 16'd3, 8'd2);
        idle_on = 1'b0;
        run_random(300);

        drain(SETTLE_CYCLES);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
